/* design/sha1_pkg.sv */
// shared types, constants and helper functions for the sha-1 hash block
package sha1_pkg;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [3:0] LAST_SLOT     = 4'd15;
    localparam logic [3:0] LEN_HI_SLOT   = 4'd14;
    localparam logic [3:0] LAST_PAD_SLOT = 4'd13;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [1:0] LAST_BYTE_POS = 2'd3;

    typedef enum logic [0:0] {
        ENTRY_WORD,
        ENTRY_FINAL
    } entry_kind_t;

    // one queue entry: a full message word, or the message tail with its length
    typedef struct packed {
        entry_kind_t kind;
        logic [31:0] word;
        logic [1:0]  nbytes;
        logic [63:0] len;
    } sha1_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_LENLO,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } core_state_t;

    // big-endian byte lane placement
    function automatic logic [31:0] place_byte(input logic [7:0] b, input logic [1:0] pos);
        logic [31:0] w;
        begin
            case (pos)
                2'd0:    w = {b, 24'h0};
                2'd1:    w = {8'h0, b, 16'h0};
                2'd2:    w = {16'h0, b, 8'h0};
                2'd3:    w = {24'h0, b};
                default: w = 32'h0;
            endcase
            return w;
        end
    endfunction

    function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [1:0] n);
        return w | place_byte(PAD_MARK, n);
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (rnd < 7'd20) begin
                f = (b & c) | (~b & d);
            end
            else if (rnd < 7'd40) begin
                f = b ^ c ^ d;
            end
            else if (rnd < 7'd60) begin
                f = (b & c) | (b & d) | (c & d);
            end
            else begin
                f = b ^ c ^ d;
            end
            return f;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        begin
            if (rnd < 7'd20) begin
                k = K_0;
            end
            else if (rnd < 7'd40) begin
                k = K_1;
            end
            else if (rnd < 7'd60) begin
                k = K_2;
            end
            else begin
                k = K_3;
            end
            return k;
        end
    endfunction

endpackage

/* design/sha1_front.sv */
// front end: packs message bytes into words, counts the length, marks the tail
module sha1_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic               s_axis_tuser,   // has_byte
    input  logic               s_axis_tlast,   // is_last
    output logic               push,
    output sha1_pkg::sha1_entry_t push_data,
    input  logic               full
);
    import sha1_pkg::*;

    logic [31:0] partial_reg, partial_next;
    logic [1:0]  bpos_reg, bpos_next;
    logic [63:0] count_reg, count_next;
    logic        pend_reg, pend_next;

    logic        acc;
    logic [31:0] byte_word;
    logic [63:0] count_add;

    assign s_axis_tready = !pend_reg && !full;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign byte_word     = partial_reg | place_byte(s_axis_tdata, bpos_reg);
    assign count_add     = count_reg + 64'd8;

    always_comb
    begin
        partial_next     = partial_reg;
        bpos_next        = bpos_reg;
        count_next       = count_reg;
        pend_next        = pend_reg;
        push             = 1'b0;
        push_data.kind   = ENTRY_WORD;
        push_data.word   = byte_word;
        push_data.nbytes = 2'd0;
        push_data.len    = count_reg;
        if (pend_reg)
        begin
            // word just completed by the last byte; now send the empty tail
            if (!full)
            begin
                push           = 1'b1;
                push_data.kind = ENTRY_FINAL;
                push_data.word = 32'h0;
                pend_next      = 1'b0;
                count_next     = 64'd0;
            end
        end
        else if (acc)
        begin
            if (s_axis_tuser)
            begin
                partial_next = byte_word;
                bpos_next    = bpos_reg + 2'd1;
                count_next   = count_add;
                if (bpos_reg == LAST_BYTE_POS)
                begin
                    push         = 1'b1;
                    partial_next = 32'h0;
                    if (s_axis_tlast)
                    begin
                        pend_next = 1'b1;
                    end
                end
                else if (s_axis_tlast)
                begin
                    push             = 1'b1;
                    push_data.kind   = ENTRY_FINAL;
                    push_data.nbytes = bpos_reg + 2'd1;
                    push_data.len    = count_add;
                    partial_next     = 32'h0;
                    bpos_next        = 2'd0;
                    count_next       = 64'd0;
                end
            end
            else if (s_axis_tlast)
            begin
                push             = 1'b1;
                push_data.kind   = ENTRY_FINAL;
                push_data.word   = partial_reg;
                push_data.nbytes = bpos_reg;
                partial_next     = 32'h0;
                bpos_next        = 2'd0;
                count_next       = 64'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 32'h0;
            bpos_reg    <= 2'd0;
            count_reg   <= 64'd0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
            bpos_reg    <= bpos_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_axis_tlast && !(s_axis_tuser && bpos_reg == LAST_BYTE_POS))
        |=> (count_reg == 64'd0 && bpos_reg == 2'd0))
        else $error("length not cleared after message end");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (bpos_reg == 2'd0 && partial_reg == 32'h0))
        else $error("pending tail with bytes still held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !full) |=> !pend_reg)
        else $error("pending tail not sent");

endmodule

/* design/sha1_fifo.sv */
// short queue of word entries between front and back end
module sha1_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sha1_pkg::sha1_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output sha1_pkg::sha1_entry_t pop_data,
    output logic                  not_empty
);
    import sha1_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sha1_entry_t     mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

endmodule

/* design/sha1_core.sv */
// back end: block loading, padding, 80-round compression and digest output
module sha1_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha1_pkg::sha1_entry_t q_data,
    input  logic                  q_valid,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word
);
    import sha1_pkg::*;

    core_state_t state_reg, state_next;
    logic [3:0]  widx_reg, widx_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        pad_reg, pad_next;
    logic        lenok_reg, lenok_next;
    logic        final_reg, final_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];

    logic [31:0] win_reg [16];
    logic [31:0] vars_reg [5];
    logic [63:0] len_reg;

    logic        shift_en;
    logic [31:0] shift_word;
    logic        load_vars;
    logic        len_capture;
    logic [31:0] sched_new;
    logic [31:0] t_val;
    logic [31:0] va, vb, vc, vd, ve;

    assign va = vars_reg[0];
    assign vb = vars_reg[1];
    assign vc = vars_reg[2];
    assign vd = vars_reg[3];
    assign ve = vars_reg[4];

    // next schedule word from fixed taps of the window
    always_comb
    begin
        sched_new = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        sched_new = {sched_new[30:0], sched_new[31]};
        t_val = {va[26:0], va[31:27]} + round_f(rnd_reg, vb, vc, vd) + ve
              + round_k(rnd_reg) + win_reg[0];
    end

    always_comb
    begin
        state_next   = state_reg;
        widx_next    = widx_reg;
        rnd_next     = rnd_reg;
        pad_next     = pad_reg;
        lenok_next   = lenok_reg;
        final_next   = final_reg;
        out_idx_next = out_idx_reg;
        for (int i = 0; i < 5; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        q_pop       = 1'b0;
        shift_en    = 1'b0;
        shift_word  = sched_new;
        load_vars   = 1'b0;
        len_capture = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    shift_en  = 1'b1;
                    widx_next = widx_reg + 4'd1;
                    if (q_data.kind == ENTRY_FINAL)
                    begin
                        shift_word  = pad_word(q_data.word, q_data.nbytes);
                        len_capture = 1'b1;
                        pad_next    = 1'b1;
                        lenok_next  = (widx_reg <= LAST_PAD_SLOT);
                    end
                    else
                    begin
                        shift_word = q_data.word;
                    end
                    if (widx_reg == LAST_SLOT)
                    begin
                        state_next = ST_ROUND;
                        load_vars  = 1'b1;
                        rnd_next   = 7'd0;
                        // a tail in the last slot leaves the length for a fresh block
                        lenok_next = 1'b1;
                        final_next = 1'b0;
                    end
                    else if (q_data.kind == ENTRY_FINAL)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                shift_en  = 1'b1;
                widx_next = widx_reg + 4'd1;
                if (widx_reg == LEN_HI_SLOT && lenok_reg)
                begin
                    shift_word = len_reg[63:32];
                    state_next = ST_LENLO;
                end
                else
                begin
                    shift_word = 32'h0;
                    if (widx_reg == LAST_SLOT)
                    begin
                        // tail spilled past the length slots: one more block
                        state_next = ST_ROUND;
                        load_vars  = 1'b1;
                        rnd_next   = 7'd0;
                        lenok_next = 1'b1;
                        final_next = 1'b0;
                    end
                end
            end
            ST_LENLO:
            begin
                shift_en   = 1'b1;
                shift_word = len_reg[31:0];
                widx_next  = widx_reg + 4'd1;
                state_next = ST_ROUND;
                load_vars  = 1'b1;
                rnd_next   = 7'd0;
                final_next = 1'b1;
            end
            ST_ROUND:
            begin
                shift_en = 1'b1;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (out_idx_reg == LAST_WORD_IDX)
                    begin
                        out_idx_next = 3'd0;
                        for (int i = 0; i < 5; i++)
                        begin
                            chain_next[i] = H_INIT[i];
                        end
                        pad_next   = 1'b0;
                        lenok_next = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            widx_reg    <= 4'd0;
            rnd_reg     <= 7'd0;
            pad_reg     <= 1'b0;
            lenok_reg   <= 1'b0;
            final_reg   <= 1'b0;
            out_idx_reg <= 3'd0;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            state_reg   <= state_next;
            widx_reg    <= widx_next;
            rnd_reg     <= rnd_next;
            pad_reg     <= pad_next;
            lenok_reg   <= lenok_next;
            final_reg   <= final_next;
            out_idx_reg <= out_idx_next;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // schedule window, working variables and length: payload only
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= shift_word;
        end
        if (load_vars)
        begin
            for (int i = 0; i < 5; i++)
            begin
                vars_reg[i] <= chain_next[i];
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            vars_reg[0] <= t_val;
            vars_reg[1] <= va;
            vars_reg[2] <= {vb[1:0], vb[31:2]};
            vars_reg[3] <= vc;
            vars_reg[4] <= vd;
        end
        if (len_capture)
        begin
            len_reg <= q_data.len;
        end
    end

    assign out_valid  = (state_reg == ST_OUT);
    assign word_index = out_idx_reg;
    assign last_word  = (out_idx_reg == LAST_WORD_IDX);

    always_comb
    begin
        case (out_idx_reg)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            3'd4:    digest_word = chain_reg[4];
            default: digest_word = chain_reg[0];
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> ($past(state_reg) == ST_ROUND && $past(rnd_reg) == LAST_ROUND))
        else $error("chain update without a full set of rounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_idx_reg <= LAST_WORD_IDX && final_reg))
        else $error("digest output out of sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LENLO) |-> (widx_reg == LAST_SLOT && lenok_reg && pad_reg))
        else $error("length low word at wrong slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (widx_reg == 4'd0))
        else $error("compression started on a partial block");

endmodule

/* design/sha1_hash.sv */
// top level of the sha-1 hash block: byte stream in, five digest words out
//
//  channel   dir  tdata                    tuser              tlast
//  s_axis    in   [7:0] data_byte          [0] has_byte       is_last
//  m_axis    out  [31:0] digest_word       [2:0] word_index   last_word
//
// a block is 16 word loads, 80 rounds and one chain add. the queue holds only
// QUEUE_DEPTH word entries, 16 bytes by default, and the front takes at most
// one byte a cycle. a message end adds padding words, one or two compressions
// and the output of five digest words. reset is asynchronous and restores the
// initial chain. the front stalls on a full queue and, after an end item that
// fills a word, until the empty tail is queued; the back holds each digest
// word until it is taken.
module sha1_hash #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // has_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha1_pkg::*;

    // word entries from the packer to the compression engine
    sha1_entry_t push_data;
    sha1_entry_t pop_data;
    logic        push;
    logic        full;
    logic        pop;
    logic        not_empty;

    // byte packing and length counting
    sha1_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    // decouples the byte side from the long compression runs
    sha1_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    // padding, rounds and digest delivery
    sha1_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (pop_data),
        .q_valid     (not_empty),
        .q_pop       (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .digest_word (m_axis_tdata),
        .word_index  (m_axis_tuser),
        .last_word   (m_axis_tlast)
    );

endmodule
